>>> src/srt_pkg.sv
package srt_pkg;

	localparam int unsigned SPEED_W = 16;
	localparam int unsigned MS_W    = 32;
	localparam int unsigned EV_W    = 7;
	localparam int unsigned MARKS   = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// event bit positions
	localparam int unsigned EV_ACC_ARM   = 0;
	localparam int unsigned EV_MARK0     = 1;
	localparam int unsigned EV_TIMEOUT   = 4;
	localparam int unsigned EV_BRAKE_ARM = 5;
	localparam int unsigned EV_BRAKE_END = 6;

	localparam int unsigned FINAL_MARK = MARKS - 1;

	localparam logic [SPEED_W-1:0] ACCEL_START_RST = 16'd500;
	localparam logic [SPEED_W-1:0] FIRST_MARK_RST  = 16'd6000;
	localparam logic [SPEED_W-1:0] SECOND_MARK_RST = 16'd10000;
	localparam logic [SPEED_W-1:0] FINAL_MARK_RST  = 16'd20000;
	localparam logic [SPEED_W-1:0] BRAKE_START_RST = 16'd9500;
	localparam logic [SPEED_W-1:0] BRAKE_END_RST   = 16'd500;
	localparam logic [MS_W-1:0]    TIMEOUT_RST     = 32'd30000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACCEL_START = 3'd0,
		CFG_FIRST_MARK  = 3'd1,
		CFG_SECOND_MARK = 3'd2,
		CFG_FINAL_MARK  = 3'd3,
		CFG_BRAKE_START = 3'd4,
		CFG_BRAKE_END   = 3'd5,
		CFG_TIMEOUT     = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [SPEED_W-1:0] accel_start_speed;
		logic [SPEED_W-1:0] first_mark_speed;
		logic [SPEED_W-1:0] second_mark_speed;
		logic [SPEED_W-1:0] final_mark_speed;
		logic [SPEED_W-1:0] brake_start_speed_limit;
		logic [SPEED_W-1:0] brake_end_speed;
		logic [MS_W-1:0]    accel_timeout_ms;
	} srt_cfg_t;

	typedef struct packed {
		logic               speed_valid;
		logic               location_valid;
		logic [SPEED_W-1:0] speed;
		logic [MS_W-1:0]    now_ms;
	} srt_item_t;

	typedef struct packed {
		logic               accel_running;
		logic               brake_running;
		logic [MS_W-1:0]    first_mark_ms;
		logic [MS_W-1:0]    second_mark_ms;
		logic [MS_W-1:0]    final_mark_ms;
		logic [MS_W-1:0]    brake_ms;
		logic [SPEED_W-1:0] brake_entry_speed;
		logic [EV_W-1:0]    events;
	} srt_result_t;

endpackage

>>> src/speed_run_timer_top.sv
// Speed run timer: acceleration and braking test timer fed by speed samples.
//
// Input channel (in_valid/in_ready) carries one sample per transaction:
// validity flags, speed in 0.01 km/h and a millisecond timestamp. Output
// channel (out_valid/out_ready) returns exactly one result per sample: run
// flags, latched mark times, last braking time, braking entry speed, events.
// Threshold registers are written via cfg_wr_en/cfg_addr/cfg_wdata by the
// user only with no transaction in flight (unenforced); unused indexes drop.
//
// A sample accepted at the input is registered, evaluated against the test
// state and, once the output register has room, lands there and raises
// out_valid. Throughput is one sample per cycle while out_ready is high; the
// state update and the result both come from a single compare/subtract pass.
//
// Reset clears both tests, all latched times and restores default thresholds.
// When the receiver stalls, the result holds in the output register; the
// input register still takes one more sample, then in_ready drops until the
// output is taken.
module speed_run_timer_top
	import srt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  speed_valid,
	input  logic                  location_valid,
	input  logic [SPEED_W-1:0]    speed,
	input  logic [MS_W-1:0]       now_ms,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  accel_running,
	output logic                  brake_running,
	output logic [MS_W-1:0]       first_mark_ms,
	output logic [MS_W-1:0]       second_mark_ms,
	output logic [MS_W-1:0]       final_mark_ms,
	output logic [MS_W-1:0]       brake_ms,
	output logic [SPEED_W-1:0]    brake_entry_speed,
	output logic [EV_W-1:0]       events
);

	srt_cfg_t    cfg;
	srt_item_t   item_s1;
	logic        valid_s1;
	srt_result_t res;
	srt_result_t res_q;
	logic        out_valid_q;
	logic        advance;

	srt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// move the registered sample into the result register when it has room
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.speed_valid    <= speed_valid;
			item_s1.location_valid <= location_valid;
			item_s1.speed          <= speed;
			item_s1.now_ms         <= now_ms;
		end
	end

	srt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cfg    (cfg),
		.item   (item_s1),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign accel_running     = res_q.accel_running;
	assign brake_running     = res_q.brake_running;
	assign first_mark_ms     = res_q.first_mark_ms;
	assign second_mark_ms    = res_q.second_mark_ms;
	assign final_mark_ms     = res_q.final_mark_ms;
	assign brake_ms          = res_q.brake_ms;
	assign brake_entry_speed = res_q.brake_entry_speed;
	assign events            = res_q.events;

endmodule

>>> src/srt_cfg.sv
module srt_cfg
	import srt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output srt_cfg_t              cfg
);

	srt_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_start_speed       <= ACCEL_START_RST;
			cfg_q.first_mark_speed        <= FIRST_MARK_RST;
			cfg_q.second_mark_speed       <= SECOND_MARK_RST;
			cfg_q.final_mark_speed        <= FINAL_MARK_RST;
			cfg_q.brake_start_speed_limit <= BRAKE_START_RST;
			cfg_q.brake_end_speed         <= BRAKE_END_RST;
			cfg_q.accel_timeout_ms        <= TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_ACCEL_START: cfg_q.accel_start_speed       <= cfg_wdata[SPEED_W-1:0];
				CFG_FIRST_MARK:  cfg_q.first_mark_speed        <= cfg_wdata[SPEED_W-1:0];
				CFG_SECOND_MARK: cfg_q.second_mark_speed       <= cfg_wdata[SPEED_W-1:0];
				CFG_FINAL_MARK:  cfg_q.final_mark_speed        <= cfg_wdata[SPEED_W-1:0];
				CFG_BRAKE_START: cfg_q.brake_start_speed_limit <= cfg_wdata[SPEED_W-1:0];
				CFG_BRAKE_END:   cfg_q.brake_end_speed         <= cfg_wdata[SPEED_W-1:0];
				CFG_TIMEOUT:     cfg_q.accel_timeout_ms        <= cfg_wdata[MS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/srt_core.sv
module srt_core
	import srt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  srt_cfg_t    cfg,
	input  srt_item_t   item,
	output srt_result_t result
);

	logic                          accel_active_q;
	logic                          brake_active_q;
	logic [MS_W-1:0]               accel_origin_q;
	logic [MS_W-1:0]               brake_origin_q;
	logic [SPEED_W-1:0]            brake_entry_q;
	logic [MARKS-1:0][MS_W-1:0]    mark_times_q;
	logic [MARKS-1:0]              mark_hit_q;
	logic [MS_W-1:0]               brake_dur_q;

	logic                          ok;
	logic                          arm;
	logic                          act;
	logic [MS_W-1:0]               origin;
	logic [MS_W-1:0]               elapsed;
	logic [MARKS-1:0][SPEED_W-1:0] marks;
	logic [MARKS-1:0]              hit_base;
	logic [MARKS-1:0][MS_W-1:0]    times_base;
	logic [MARKS-1:0]              latch;
	logic                          timeout;
	logic                          b_arm;
	logic                          b_act;
	logic [MS_W-1:0]               b_origin;
	logic                          b_done;

	logic                          accel_active_d;
	logic                          brake_active_d;
	logic [MS_W-1:0]               accel_origin_d;
	logic [MS_W-1:0]               brake_origin_d;
	logic [SPEED_W-1:0]            brake_entry_d;
	logic [MARKS-1:0][MS_W-1:0]    mark_times_d;
	logic [MARKS-1:0]              mark_hit_d;
	logic [MS_W-1:0]               brake_dur_d;
	logic [EV_W-1:0]               events;

	assign marks[0] = cfg.first_mark_speed;
	assign marks[1] = cfg.second_mark_speed;
	assign marks[2] = cfg.final_mark_speed;

	always_comb begin
		ok  = item.speed_valid && item.location_valid;

		// acceleration: arming restarts the origin and drops latched marks
		arm = ok && !accel_active_q && (item.speed >= cfg.accel_start_speed)
			&& (item.speed < cfg.first_mark_speed);
		act        = accel_active_q || arm;
		origin     = arm ? item.now_ms : accel_origin_q;
		elapsed    = item.now_ms - origin;
		hit_base   = arm ? '0 : mark_hit_q;
		times_base = arm ? '0 : mark_times_q;
		for (int k = 0; k < MARKS; k++) begin
			latch[k] = ok && act && !hit_base[k] && (item.speed >= marks[k]);
		end
		timeout = ok && act && (elapsed > cfg.accel_timeout_ms);

		for (int k = 0; k < MARKS; k++) begin
			mark_times_d[k] = latch[k] ? elapsed : times_base[k];
		end
		mark_hit_d     = hit_base | latch;
		accel_origin_d = origin;
		accel_active_d = ok ? (act && !latch[FINAL_MARK] && !timeout) : accel_active_q;

		// braking
		b_arm    = ok && !brake_active_q && (item.speed >= cfg.brake_start_speed_limit);
		b_act    = brake_active_q || b_arm;
		b_origin = b_arm ? item.now_ms : brake_origin_q;
		b_done   = ok && b_act && (item.speed <= cfg.brake_end_speed);

		brake_origin_d = b_origin;
		brake_entry_d  = b_arm ? item.speed : brake_entry_q;
		brake_dur_d    = b_done ? (item.now_ms - b_origin) : brake_dur_q;
		brake_active_d = ok ? (b_act && !b_done) : brake_active_q;

		events = '0;
		events[EV_ACC_ARM]                  = arm;
		events[EV_MARK0 +: MARKS]           = latch;
		events[EV_TIMEOUT]                  = timeout;
		events[EV_BRAKE_ARM]                = b_arm;
		events[EV_BRAKE_END]                = b_done;

		result.accel_running     = accel_active_d;
		result.brake_running     = brake_active_d;
		result.first_mark_ms     = mark_times_d[0];
		result.second_mark_ms    = mark_times_d[1];
		result.final_mark_ms     = mark_times_d[2];
		result.brake_ms          = brake_dur_d;
		result.brake_entry_speed = brake_entry_d;
		result.events            = events;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_active_q <= 1'b0;
			brake_active_q <= 1'b0;
			accel_origin_q <= '0;
			brake_origin_q <= '0;
			brake_entry_q  <= '0;
			mark_times_q   <= '0;
			mark_hit_q     <= '0;
			brake_dur_q    <= '0;
		end else if (en) begin
			accel_active_q <= accel_active_d;
			brake_active_q <= brake_active_d;
			accel_origin_q <= accel_origin_d;
			brake_origin_q <= brake_origin_d;
			brake_entry_q  <= brake_entry_d;
			mark_times_q   <= mark_times_d;
			mark_hit_q     <= mark_hit_d;
			brake_dur_q    <= brake_dur_d;
		end
	end

`ifndef ASSERT_OFF
	// a mark without its flag never holds a time
	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(mark_hit_q[0] || mark_times_q[0] == '0) && (mark_hit_q[1] || mark_times_q[1] == '0)
		&& (mark_hit_q[2] || mark_times_q[2] == '0))
		else $error("mark time set without its hit flag");

	a_invalid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !ok) |=> ($stable(accel_active_q) && $stable(brake_active_q)
		&& $stable(mark_hit_q) && $stable(brake_dur_q) && $stable(brake_entry_q)))
		else $error("invalid sample changed state");

	a_final_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(en && latch[FINAL_MARK]) |=> !accel_active_q)
		else $error("acceleration test still running after final mark");

	a_brake_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(en && b_done) |=> !brake_active_q)
		else $error("braking test still running after completion");
`endif

endmodule
